// ===== hdl/flow_vector_to_color_unit_assert.svh =====
// Assertion macros for the flow vector to color unit.
// Included by the modules that carry concurrent assertions.
`ifndef FLOW_VECTOR_TO_COLOR_UNIT_ASSERT_SVH
`define FLOW_VECTOR_TO_COLOR_UNIT_ASSERT_SVH
// Checks an implication on the rising clock edge, disabled while in reset.
`define FVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checks a property that must also hold during reset.
`define FVC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`endif

// ===== hdl/fvc_pkg.sv =====
// Package for the flow vector to color unit: widths, tables and the queue entry type.
// Used by every module of the unit; depends on nothing.
package fvc_pkg;

    localparam int FLOW_WIDTH = 16;
    localparam int MAG_WIDTH = 16;
    localparam int SQ_WIDTH = 2 * FLOW_WIDTH + 1;
    localparam int CORDIC_STEPS = 15;
    localparam int WHEEL_SIZE = 55;
    localparam int CORDIC_WIDTH = FLOW_WIDTH + 8 + 3;
    localparam logic [15:0] MIN_MAG_RESET = 16'd1024;

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // One classified transaction handed from the front to the back.
    typedef struct packed {
        logic                          kind;
        logic                          frame_start;
        logic signed [FLOW_WIDTH-1:0]  flow_x;
        logic signed [FLOW_WIDTH-1:0]  flow_y;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_DECIDE, ST_CORDIC, ST_DIVIDE, ST_MIX, ST_OUT
    } back_state_t;

    // Arctangent of 2^-i in 1/65536 turns.
    function automatic logic [15:0] turn_angle(input logic [3:0] i);
        logic [15:0] a;
        case (i)
            4'd0: a = 16'd8192;
            4'd1: a = 16'd4836;
            4'd2: a = 16'd2555;
            4'd3: a = 16'd1297;
            4'd4: a = 16'd651;
            4'd5: a = 16'd326;
            4'd6: a = 16'd163;
            4'd7: a = 16'd81;
            4'd8: a = 16'd41;
            4'd9: a = 16'd20;
            4'd10: a = 16'd10;
            4'd11: a = 16'd5;
            4'd12: a = 16'd3;
            4'd13: a = 16'd1;
            4'd14: a = 16'd1;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // Color wheel entry as packed {r, g, b}.
    // Segment ramps use exact reciprocal products over their short index ranges.
    function automatic logic [23:0] wheel_entry(input logic [5:0] k);
        int r, g, b, kk;
        r = 0; g = 0; b = 0;
        kk = int'(k);
        if (kk < 15) begin
            r = 255; g = 17 * kk;
        end else if (kk < 21) begin
            r = 255 - ((85 * (kk - 15)) >> 1); g = 255;
        end else if (kk < 25) begin
            g = 255; b = (255 * (kk - 21)) >> 2;
        end else if (kk < 36) begin
            g = 255 - ((255 * (kk - 25) * 5958) >> 16); b = 255;
        end else if (kk < 49) begin
            r = (255 * (kk - 36) * 5042) >> 16; b = 255;
        end else if (kk < WHEEL_SIZE) begin
            r = 255; b = 255 - ((85 * (kk - 49)) >> 1);
        end
        return {r[7:0], g[7:0], b[7:0]};
    endfunction

endpackage

// ===== hdl/fvc_front.sv =====
// Front part: accepts input transactions into a two-entry queue.
// Depends on fvc_pkg.
module fvc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fvc_pkg::item_t      in_item,
    output logic                q_valid,
    input  logic                q_ready,
    output fvc_pkg::item_t      q_item
);
    fvc_pkg::item_t mem_reg [2];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `include "flow_vector_to_color_unit_assert.svh"
    `FVC_ASSERT(a_no_overflow, count_reg == 2'd2 |-> !s_ready, "queue full but ready")
    `FVC_ASSERT(a_count_range, count_reg != 2'd3, "queue count out of range")
    `FVC_ASSERT(a_full_holds, (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2, "full queue lost an entry")
endmodule

// ===== hdl/fvc_back.sv =====
// Back part: square root, CORDIC phase, serial divide and color mixing.
// Depends on fvc_pkg.
module fvc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         min_magnitude,
    input  logic                q_valid,
    output logic                q_ready,
    input  fvc_pkg::item_t      q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_red,
    output logic [7:0]          m_green,
    output logic [7:0]          m_blue
);
    localparam int SW = fvc_pkg::SQ_WIDTH;
    localparam int RW = SW + 1;
    localparam int CW = fvc_pkg::CORDIC_WIDTH;
    localparam int FLOW_ABS = fvc_pkg::FLOW_WIDTH;

    fvc_pkg::back_state_t state_reg, state_next;
    fvc_pkg::item_t item_reg;
    fvc_pkg::mag_t max_reg, mag_reg;
    logic [SW:0] op_reg, bit_reg;
    logic [RW-1:0] res_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic [15:0] ph_reg;
    logic [4:0] step_reg;
    logic [16:0] ratio_reg;
    logic [32:0] rem_reg;
    logic beyond_reg;
    logic [1:0] ch_reg;
    logic mix_phase_reg;
    logic [24:0] cmix_reg;
    logic [7:0] rgb_reg [3];
    logic [23:0] c0, c1;
    logic [21:0] w;
    logic [15:0] f;
    logic [5:0] k0, k1;
    logic [7:0] e0, e1;
    logic [24:0] cmix, gap;
    logic [7:0] chv;
    logic [SW:0] sum_sq;
    logic [FLOW_ABS-1:0] ax, ay;
    logic [2*FLOW_ABS-1:0] sq_x, sq_y;
    logic [RW-1:0] mag_full;
    logic stepping;

    // Absolute values and squared length of the incoming vector.
    assign ax = q_item.flow_x[FLOW_ABS-1] ? FLOW_ABS'(-q_item.flow_x) : FLOW_ABS'(q_item.flow_x);
    assign ay = q_item.flow_y[FLOW_ABS-1] ? FLOW_ABS'(-q_item.flow_y) : FLOW_ABS'(q_item.flow_y);
    assign sq_x = ax * ax;
    assign sq_y = ay * ay;
    assign sum_sq = (SW+1)'(sq_x) + (SW+1)'(sq_y);
    assign mag_full = res_reg;
    assign stepping = (state_reg == fvc_pkg::ST_CORDIC) || (state_reg == fvc_pkg::ST_DIVIDE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fvc_pkg::ST_IDLE: if (q_valid) state_next = fvc_pkg::ST_SQRT;
            fvc_pkg::ST_SQRT: if (bit_reg == '0) state_next = fvc_pkg::ST_DECIDE;
            fvc_pkg::ST_DECIDE: begin
                if (!item_reg.kind) state_next = fvc_pkg::ST_IDLE;
                else if (mag_reg < min_magnitude || max_reg == '0) state_next = fvc_pkg::ST_OUT;
                else state_next = fvc_pkg::ST_CORDIC;
            end
            fvc_pkg::ST_CORDIC: if (step_reg == 5'(fvc_pkg::CORDIC_STEPS))
                state_next = beyond_reg ? fvc_pkg::ST_MIX : fvc_pkg::ST_DIVIDE;
            fvc_pkg::ST_DIVIDE: if (step_reg == 5'd17) state_next = fvc_pkg::ST_MIX;
            fvc_pkg::ST_MIX: if (ch_reg == 2'd2 && mix_phase_reg) state_next = fvc_pkg::ST_OUT;
            fvc_pkg::ST_OUT: if (m_ready) state_next = fvc_pkg::ST_IDLE;
            default: state_next = fvc_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        q_ready = (state_reg == fvc_pkg::ST_IDLE);
        m_valid = (state_reg == fvc_pkg::ST_OUT);
        m_red = rgb_reg[0];
        m_green = rgb_reg[1];
        m_blue = rgb_reg[2];
    end

    // Wheel blend for the current channel, then saturation from the registered blend.
    always_comb begin
        w = 22'(ph_reg) * 22'd54;
        k0 = w[21:16];
        k1 = (k0 == 6'(fvc_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0 + 6'd1;
        f = w[15:0];
        c0 = fvc_pkg::wheel_entry(k0);
        c1 = fvc_pkg::wheel_entry(k1);
        e0 = c0[8*(2-ch_reg) +: 8];
        e1 = c1[8*(2-ch_reg) +: 8];
        cmix = (25'(17'h10000 - 17'(f)) * 25'(e0)) + (25'(f) * 25'(e1));
        gap = 25'd16711680 - cmix_reg;
        if (beyond_reg) begin
            chv = 8'((27'(cmix_reg) * 27'd3) >> 18);
        end else begin
            chv = 8'(((42'd255 << 32) - 42'(ratio_reg) * 42'(gap)) >> 32);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fvc_pkg::ST_IDLE;
            max_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == fvc_pkg::ST_DECIDE && !item_reg.kind) begin
                if (item_reg.frame_start) max_reg <= (mag_reg > 16'd0) ? mag_reg : '0;
                else if (mag_reg > max_reg) max_reg <= mag_reg;
            end
        end
    end

    // Datapath: one square root bit pair, CORDIC step or quotient bit per cycle.
    always_ff @(posedge aclk) begin
        case (state_reg)
            fvc_pkg::ST_IDLE: begin
                item_reg <= q_item;
                op_reg <= sum_sq;
                res_reg <= '0;
                bit_reg <= (SW+1)'(1) << (2 * (SW / 2));
                for (int c = 0; c < 3; c++) rgb_reg[c] <= 8'd0;
            end
            fvc_pkg::ST_SQRT: begin
                if (bit_reg != '0) begin
                    if (op_reg >= (SW+1)'(res_reg) + bit_reg) begin
                        op_reg <= op_reg - ((SW+1)'(res_reg) + bit_reg);
                        res_reg <= RW'(((SW+1)'(res_reg) >> 1) + bit_reg);
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end else begin
                    mag_reg <= (mag_full > RW'(16'hFFFF)) ? 16'hFFFF : 16'(mag_full);
                end
            end
            fvc_pkg::ST_DECIDE: begin
                beyond_reg <= mag_reg > max_reg;
                step_reg <= '0;
                ch_reg <= '0;
                mix_phase_reg <= 1'b0;
                if (item_reg.flow_x < 0) begin
                    cx_reg <= -(CW'(item_reg.flow_x) <<< 8);
                    cy_reg <= -(CW'(item_reg.flow_y) <<< 8);
                    ph_reg <= 16'h8000;
                end else begin
                    cx_reg <= CW'(item_reg.flow_x) <<< 8;
                    cy_reg <= CW'(item_reg.flow_y) <<< 8;
                    ph_reg <= 16'h0000;
                end
                ratio_reg <= '0;
                rem_reg <= '0;
            end
            fvc_pkg::ST_CORDIC: begin
                if (step_reg < 5'(fvc_pkg::CORDIC_STEPS)) begin
                    if (cy_reg >= 0) begin
                        cx_reg <= cx_reg + (cy_reg >>> step_reg);
                        cy_reg <= cy_reg - (cx_reg >>> step_reg);
                        ph_reg <= ph_reg + fvc_pkg::turn_angle(step_reg[3:0]);
                    end else begin
                        cx_reg <= cx_reg - (cy_reg >>> step_reg);
                        cy_reg <= cy_reg + (cx_reg >>> step_reg);
                        ph_reg <= ph_reg - fvc_pkg::turn_angle(step_reg[3:0]);
                    end
                    step_reg <= step_reg + 5'd1;
                end else begin
                    if (item_reg.flow_x == 0 && item_reg.flow_y == 0) ph_reg <= '0;
                    step_reg <= '0;
                    rem_reg <= 33'(mag_reg);
                end
            end
            fvc_pkg::ST_DIVIDE: begin
                if (step_reg < 5'd17) begin
                    if (step_reg == 5'd0) begin
                        if (rem_reg >= 33'(max_reg)) begin
                            rem_reg <= (rem_reg - 33'(max_reg)) << 1;
                            ratio_reg <= 17'd1;
                        end else begin
                            rem_reg <= rem_reg << 1;
                        end
                    end else if (rem_reg >= 33'(max_reg)) begin
                        rem_reg <= (rem_reg - 33'(max_reg)) << 1;
                        ratio_reg <= {ratio_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= rem_reg << 1;
                        ratio_reg <= {ratio_reg[15:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                end
            end
            fvc_pkg::ST_MIX: begin
                if (!mix_phase_reg) begin
                    cmix_reg <= cmix;
                end else begin
                    rgb_reg[ch_reg] <= chv;
                    ch_reg <= ch_reg + 2'd1;
                end
                mix_phase_reg <= ~mix_phase_reg;
            end
            default: begin
            end
        endcase
    end

    `include "flow_vector_to_color_unit_assert.svh"
    `FVC_ASSERT(a_out_hold, (m_valid && !m_ready) |=> m_valid && $stable(m_red), "result dropped")
    `FVC_ASSERT(a_no_take_busy, !(q_ready && m_valid), "input taken while result pending")
    `FVC_ASSERT(a_step_bound, stepping |-> step_reg <= 5'd17, "step counter runaway")
endmodule

// ===== hdl/flow_vector_to_color_unit.sv =====
// Top level of the flow vector to color unit.
// Depends on fvc_pkg, fvc_front and fvc_back.
//
// A measure sample passes through the shared back unit: it is taken in the idle state,
// the bit-pair square root runs its 17 steps and a final register step, and the decide
// state updates the frame maximum. A black colorize sample goes from decide to output.
// A colored sample adds the 15-step CORDIC phase and a blend and a store phase per color
// channel; unless it is beyond the maximum, a 17-step serial divide by the frame maximum
// comes before the mix. Each result then waits for m_ready. A two-entry queue in front
// accepts transactions while the back is busy. Measure samples give no result. The user
// ensures min_magnitude is written only when the unit is idle; it is not enforced here.
module flow_vector_to_color_unit (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_we,
    input  logic [15:0]                              cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_kind,
    input  logic signed [fvc_pkg::FLOW_WIDTH-1:0]    s_flow_x,
    input  logic signed [fvc_pkg::FLOW_WIDTH-1:0]    s_flow_y,
    input  logic                                     s_frame_start,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [7:0]                               m_red,
    output logic [7:0]                               m_green,
    output logic [7:0]                               m_blue
);
    logic [15:0] min_mag_reg;
    fvc_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    // Threshold register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_mag_reg <= fvc_pkg::MIN_MAG_RESET;
        end else if (cfg_we) begin
            min_mag_reg <= cfg_wdata;
        end
    end

    assign in_item = '{kind: s_kind, frame_start: s_frame_start,
                       flow_x: s_flow_x, flow_y: s_flow_y};

    fvc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    fvc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .min_magnitude(min_mag_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue)
    );
endmodule
